// ----- sv/spcf_pkg.sv -----
// Shared types and constants of the semantic point confidence filter.
package spcf_pkg;

	localparam int MAX_CLASSES = 16;

	localparam logic [15:0] LUMA_WR = 16'd19595;
	localparam logic [15:0] LUMA_WG = 16'd38470;
	localparam logic [15:0] LUMA_WB = 16'd7471;

	localparam logic [7:0]  CONF_MAX     = 8'd255;
	localparam logic [7:0]  CONF_FAR     = 8'd45;
	localparam logic [15:0] CONF_SPAN_SQ = 16'd44100;

	localparam int DIV_STEPS      = 16;
	localparam int DIV_PER_STAGE  = 2;
	localparam int DIV_STAGES     = DIV_STEPS / DIV_PER_STAGE;
	localparam int SQRT_STEPS     = 8;
	localparam int SQRT_PER_STAGE = 2;
	localparam int SQRT_STAGES    = SQRT_STEPS / SQRT_PER_STAGE;

	localparam logic [1:0] CFG_PROB_THR = 2'd0;
	localparam logic [1:0] CFG_CONF_THR = 2'd1;
	localparam logic [1:0] CFG_NEAR     = 2'd2;
	localparam logic [1:0] CFG_FAR      = 2'd3;

	typedef struct packed {
		logic       keep;
		logic       use_fixed;
		logic [7:0] fixed_conf;
	} ctl_t;

	typedef struct packed {
		logic [15:0] rem;
		logic [15:0] lo;
		logic [15:0] span;
	} div_t;

	typedef struct packed {
		logic [15:0] rad;
		logic [9:0]  rem;
		logic [7:0]  root;
	} sqrt_t;

endpackage

// ----- sv/spcf_front.sv -----
// Front stages: luma, keep decision, depth range classification and numerator product.
module spcf_front #(
	parameter int DEPTH_BITS = 16
) (
	input  logic                  clk,
	input  logic                  en_s1,
	input  logic                  en_s2,
	input  logic [16:0]           class_prob,
	input  logic [3:0]            class_index,
	input  logic [7:0]            unc_red,
	input  logic [7:0]            unc_green,
	input  logic [7:0]            unc_blue,
	input  logic                  point_finite,
	input  logic [DEPTH_BITS-1:0] depth_mm,
	input  logic [16:0]           prob_thr,
	input  logic [7:0]            conf_thr,
	input  logic [15:0]           near_dist,
	input  logic [15:0]           far_dist,
	output spcf_pkg::ctl_t        ctl_s1,
	output spcf_pkg::div_t        div_s2
);
	import spcf_pkg::*;

	localparam int ZW = (DEPTH_BITS > 16) ? DEPTH_BITS : 16;

	logic [23:0]  luma_sum;
	logic [7:0]   luma;
	logic [7:0]   seg_conf;
	logic [ZW-1:0] z_ext;
	logic [ZW-1:0] near_ext;
	logic [ZW-1:0] far_ext;
	logic         lt_near;
	logic         gt_far;
	ctl_t         ctl_nxt;
	logic [15:0]  d_s1;
	logic [15:0]  span_s1;
	logic [31:0]  prod;

	assign luma_sum = 24'(unc_red) * 24'(LUMA_WR) + 24'(unc_green) * 24'(LUMA_WG)
		+ 24'(unc_blue) * 24'(LUMA_WB);
	assign luma     = luma_sum[23:16];
	assign seg_conf = CONF_MAX - luma;

	assign z_ext    = ZW'(depth_mm);
	assign near_ext = ZW'(near_dist);
	assign far_ext  = ZW'(far_dist);
	assign lt_near  = z_ext < near_ext;
	assign gt_far   = z_ext > far_ext;

	always_comb begin
		ctl_nxt.keep = point_finite && (class_prob >= prob_thr) && (seg_conf >= conf_thr)
			&& ({5'd0, class_index} < 9'(MAX_CLASSES));
		ctl_nxt.use_fixed  = lt_near || gt_far || (far_dist == near_dist);
		ctl_nxt.fixed_conf = (!lt_near && gt_far) ? CONF_FAR : CONF_MAX;
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			ctl_s1  <= ctl_nxt;
			d_s1    <= 16'(z_ext - near_ext);
			span_s1 <= far_dist - near_dist;
		end
	end

	// quotient is below 2^16 when d <= span, so the upper half seeds the remainder
	assign prod = {16'd0, d_s1} * {16'd0, CONF_SPAN_SQ};

	always_ff @(posedge clk) begin
		if (en_s2) begin
			div_s2.rem  <= prod[31:16];
			div_s2.lo   <= prod[15:0];
			div_s2.span <= span_s1;
		end
	end

endmodule

// ----- sv/spcf_div_stage.sv -----
// One pipeline stage of the restoring divider, DIV_PER_STAGE quotient bits per stage.
module spcf_div_stage (
	input  logic           clk,
	input  logic           en,
	input  spcf_pkg::div_t div_in,
	output spcf_pkg::div_t div_out
);
	import spcf_pkg::*;

	div_t div_nxt;

	always_comb begin
		logic [16:0] t;
		div_nxt = div_in;
		for (int i = 0; i < DIV_PER_STAGE; i++) begin
			t = {div_nxt.rem, div_nxt.lo[15]};
			div_nxt.lo = {div_nxt.lo[14:0], 1'b0};
			if (t >= {1'b0, div_nxt.span}) begin
				t = t - {1'b0, div_nxt.span};
				div_nxt.lo[0] = 1'b1;
			end
			div_nxt.rem = t[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_out <= div_nxt;
		end
	end

endmodule

// ----- sv/spcf_sqrt_stage.sv -----
// One pipeline stage of the digit-by-digit integer square root.
module spcf_sqrt_stage (
	input  logic            clk,
	input  logic            en,
	input  spcf_pkg::sqrt_t sq_in,
	output spcf_pkg::sqrt_t sq_out
);
	import spcf_pkg::*;

	sqrt_t sq_nxt;

	always_comb begin
		logic [11:0] r;
		logic [9:0]  trial;
		sq_nxt = sq_in;
		for (int i = 0; i < SQRT_PER_STAGE; i++) begin
			r = {sq_nxt.rem, sq_nxt.rad[15:14]};
			sq_nxt.rad = {sq_nxt.rad[13:0], 2'b00};
			trial = {sq_nxt.root, 2'b01};
			if (r >= {2'b00, trial}) begin
				r = r - {2'b00, trial};
				sq_nxt.root = {sq_nxt.root[6:0], 1'b1};
			end else begin
				sq_nxt.root = {sq_nxt.root[6:0], 1'b0};
			end
			sq_nxt.rem = r[9:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_out <= sq_nxt;
		end
	end

endmodule

// ----- sv/semantic_point_confidence_filter_top.sv -----
// Top level of the semantic point confidence filter pipeline.
//
// Input channel: one beat per pixel and class (in_valid / in_stall). Output channel:
// exactly one result beat per input beat, in order (out_valid / out_stall).
// A result carries keep, the pass-through class, coordinates and colour, and a
// depth confidence (45..255 when kept, 0 otherwise).
// Throughput is one beat per cycle unless out_stall backs the pipeline up. A beat passes
// from acceptance to out_valid through fifteen register stages: two front stages (luma and range checks,
// then the 44100*d product), eight divider stages of two quotient bits each, four
// square root stages of two root bits each, and the output register.
// Each stage has its own valid bit and advances when it is empty or the stage
// after it advances, so bubbles close up under out_stall and in_stall rises only
// once every stage is full. No beat is lost or repeated.
// Configuration: cfg_we writes register cfg_index from cfg_wdata at a clock edge
// (0 probability threshold, 1 confidence threshold, 2 near, 3 far distance).
// Write only while the pipeline is empty.
// Reset clears all valid bits and loads the default thresholds and distances.
module semantic_point_confidence_filter_top #(
	parameter int DEPTH_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [16:0]           cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [16:0]           class_prob,
	input  logic [3:0]            class_index,
	input  logic [7:0]            unc_red,
	input  logic [7:0]            unc_green,
	input  logic [7:0]            unc_blue,
	input  logic                  point_finite,
	input  logic signed [15:0]    pos_x_mm,
	input  logic signed [15:0]    pos_y_mm,
	input  logic [DEPTH_BITS-1:0] depth_mm,
	input  logic [23:0]           point_color,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  keep,
	output logic [3:0]            class_out,
	output logic signed [15:0]    x_out,
	output logic signed [15:0]    y_out,
	output logic [DEPTH_BITS-1:0] z_out,
	output logic [23:0]           color_out,
	output logic [7:0]            depth_confidence
);
	import spcf_pkg::*;

	localparam int NS = 2 + DIV_STAGES + SQRT_STAGES + 1;

	typedef struct packed {
		logic [3:0]            cls;
		logic [15:0]           x;
		logic [15:0]           y;
		logic [DEPTH_BITS-1:0] z;
		logic [23:0]           color;
	} pass_t;

	logic [16:0] prob_thr_q;
	logic [7:0]  conf_thr_q;
	logic [15:0] near_q;
	logic [15:0] far_q;

	logic [NS:1] valid_s;
	logic [NS:1] vin;
	logic [NS:1] en;

	ctl_t  ctl_s  [1:NS-1];
	pass_t pass_s [1:NS-1];
	div_t  div_s  [0:DIV_STAGES];
	sqrt_t sq_s   [0:SQRT_STAGES];
	logic [7:0] conf_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prob_thr_q <= 17'd32768;
			conf_thr_q <= 8'd128;
			near_q     <= 16'd500;
			far_q      <= 16'd6000;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PROB_THR: prob_thr_q <= cfg_wdata;
				CFG_CONF_THR: conf_thr_q <= cfg_wdata[7:0];
				CFG_NEAR:     near_q     <= cfg_wdata[15:0];
				CFG_FAR:      far_q      <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// stage advance chain
	assign en[NS] = !valid_s[NS] || !out_stall;
	genvar k;
	generate
		for (k = 1; k < NS; k++) begin : g_en
			assign en[k] = !valid_s[k] || en[k+1];
		end
	endgenerate

	assign in_stall = !en[1];
	assign vin      = {valid_s[NS-1:1], in_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			for (int i = 1; i <= NS; i++) begin
				if (en[i]) begin
					valid_s[i] <= vin[i];
				end
			end
		end
	end

	spcf_front #(
		.DEPTH_BITS(DEPTH_BITS)
	) u_front (
		.clk          (clk),
		.en_s1        (en[1]),
		.en_s2        (en[2]),
		.class_prob   (class_prob),
		.class_index  (class_index),
		.unc_red      (unc_red),
		.unc_green    (unc_green),
		.unc_blue     (unc_blue),
		.point_finite (point_finite),
		.depth_mm     (depth_mm),
		.prob_thr     (prob_thr_q),
		.conf_thr     (conf_thr_q),
		.near_dist    (near_q),
		.far_dist     (far_q),
		.ctl_s1       (ctl_s[1]),
		.div_s2       (div_s[0])
	);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			pass_s[1] <= '{cls: class_index, x: pos_x_mm, y: pos_y_mm, z: depth_mm,
				color: point_color};
		end
	end

	generate
		for (k = 2; k < NS; k++) begin : g_side
			always_ff @(posedge clk) begin
				if (en[k]) begin
					ctl_s[k]  <= ctl_s[k-1];
					pass_s[k] <= pass_s[k-1];
				end
			end
		end

		for (k = 0; k < DIV_STAGES; k++) begin : g_div
			spcf_div_stage u_div (
				.clk     (clk),
				.en      (en[3+k]),
				.div_in  (div_s[k]),
				.div_out (div_s[k+1])
			);
		end
	endgenerate

	assign sq_s[0] = '{rad: div_s[DIV_STAGES].lo, rem: 10'd0, root: 8'd0};

	generate
		for (k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
			spcf_sqrt_stage u_sqrt (
				.clk    (clk),
				.en     (en[3+DIV_STAGES+k]),
				.sq_in  (sq_s[k]),
				.sq_out (sq_s[k+1])
			);
		end
	endgenerate

	always_comb begin
		if (!ctl_s[NS-1].keep) begin
			conf_nxt = 8'd0;
		end else if (ctl_s[NS-1].use_fixed) begin
			conf_nxt = ctl_s[NS-1].fixed_conf;
		end else begin
			conf_nxt = CONF_MAX - sq_s[SQRT_STAGES].root;
		end
	end

	always_ff @(posedge clk) begin
		if (en[NS]) begin
			keep             <= ctl_s[NS-1].keep;
			class_out        <= pass_s[NS-1].cls;
			x_out            <= pass_s[NS-1].x;
			y_out            <= pass_s[NS-1].y;
			z_out            <= pass_s[NS-1].z;
			color_out        <= pass_s[NS-1].color;
			depth_confidence <= conf_nxt;
		end
	end

	assign out_valid = valid_s[NS];

	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !keep |-> depth_confidence == 8'd0)
		else $error("dropped point with nonzero depth confidence");

	a_kept_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && keep |-> depth_confidence >= CONF_FAR)
		else $error("kept point below far confidence");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s[1] && out_valid && out_stall)
		else $error("input stalled with room in the pipeline");

	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[NS-1] && !ctl_s[NS-1].use_fixed |-> sq_s[SQRT_STAGES].root <= 8'd210)
		else $error("square root above span");

endmodule

// ----- tb/semantic_point_confidence_filter_top_test.sv -----
// Self-checking testbench of the semantic point confidence filter top level.
module semantic_point_confidence_filter_top_test;
	import spcf_pkg::*;

	localparam int          LIMIT_CYCLES = 400000;
	localparam int          DRAIN_CYCLES = 30;
	localparam int          HOLD_CYCLES  = 300;
	localparam int          PHASE_ITEMS  = 185;
	localparam int unsigned W_RED        = 19595;
	localparam int unsigned W_GREEN      = 38470;
	localparam int unsigned W_BLUE       = 7471;
	localparam int unsigned SPAN_SQ      = 44100;

	typedef struct packed {
		logic [16:0]        prob;
		logic [3:0]         cls;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic               finite;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [15:0]        z;
		logic [23:0]        color;
	} pixel_t;

	typedef struct packed {
		logic               keep;
		logic [3:0]         cls;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [15:0]        z;
		logic [23:0]        color;
		logic [7:0]         dconf;
	} point_t;

	typedef enum int {FLOW, LIGHT, HEAVY, TOGGLE} stall_mode_t;

	class kept_point_board;
		int unsigned prob_thr = 32768;
		int unsigned conf_thr = 128;
		int unsigned near_mm  = 500;
		int unsigned far_mm   = 6000;
		int          errors   = 0;
		point_t      expected_points[$];

		function void set_reg(logic [1:0] idx, int unsigned v);
			case (idx)
				CFG_PROB_THR: prob_thr = v & 32'h1ffff;
				CFG_CONF_THR: conf_thr = v & 32'hff;
				CFG_NEAR:     near_mm  = v & 32'hffff;
				default:      far_mm   = v & 32'hffff;
			endcase
		endfunction

		function int unsigned depth_conf(int unsigned z);
			longint unsigned span, q;
			int unsigned     root;
			if (z < near_mm) return 255;
			if (z > far_mm) return 45;
			span = far_mm - near_mm;
			if (span == 0) return 255;
			q = (longint'(SPAN_SQ) * (z - near_mm)) / span;
			root = 0;
			while ((root + 1) * (root + 1) <= q) root++;
			return 255 - root;
		endfunction

		function void note_pixel(pixel_t px);
			int unsigned luma, seg;
			point_t      pt;
			luma = (W_RED * px.red + W_GREEN * px.green + W_BLUE * px.blue) >> 16;
			seg = 255 - luma;
			pt.keep  = px.finite && (px.prob >= prob_thr) && (seg >= conf_thr) &&
				(px.cls < MAX_CLASSES);
			pt.cls   = px.cls;
			pt.x     = px.x;
			pt.y     = px.y;
			pt.z     = px.z;
			pt.color = px.color;
			pt.dconf = pt.keep ? 8'(depth_conf(px.z)) : 8'd0;
			expected_points.insert(expected_points.size(), pt);
		endfunction

		function void compare(string field, int e, int a);
			if (e != a) begin
				errors++;
				$display("%0t: %s expected %0d got %0d", $time, field, e, a);
			end
		endfunction

		function void check_point(point_t act);
			point_t e;
			if (expected_points.size() == 0) begin
				errors++;
				$display("%0t: result beat with none expected, keep %0d class %0d",
					$time, act.keep, act.cls);
				return;
			end
			e = expected_points[0];
			expected_points.delete(0);
			compare("keep", e.keep, act.keep);
			compare("class_out", e.cls, act.cls);
			compare("x_out", e.x, act.x);
			compare("y_out", e.y, act.y);
			compare("z_out", e.z, act.z);
			compare("color_out", e.color, act.color);
			compare("depth_confidence", e.dconf, act.dconf);
		endfunction

		function int pending();
			return expected_points.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [1:0]         cfg_index = '0;
	logic [16:0]        cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [16:0]        class_prob = '0;
	logic [3:0]         class_index = '0;
	logic [7:0]         unc_red = '0;
	logic [7:0]         unc_green = '0;
	logic [7:0]         unc_blue = '0;
	logic               point_finite = 1'b0;
	logic signed [15:0] pos_x_mm = '0;
	logic signed [15:0] pos_y_mm = '0;
	logic [15:0]        depth_mm = '0;
	logic [23:0]        point_color = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               keep;
	logic [3:0]         class_out;
	logic signed [15:0] x_out;
	logic signed [15:0] y_out;
	logic [15:0]        z_out;
	logic [23:0]        color_out;
	logic [7:0]         depth_confidence;

	bit                 hold_req = 1'b0;
	int                 cycles = 0;
	kept_point_board    board = new();

	semantic_point_confidence_filter_top u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.class_prob       (class_prob),
		.class_index      (class_index),
		.unc_red          (unc_red),
		.unc_green        (unc_green),
		.unc_blue         (unc_blue),
		.point_finite     (point_finite),
		.pos_x_mm         (pos_x_mm),
		.pos_y_mm         (pos_y_mm),
		.depth_mm         (depth_mm),
		.point_color      (point_color),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.keep             (keep),
		.class_out        (class_out),
		.x_out            (x_out),
		.y_out            (y_out),
		.z_out            (z_out),
		.color_out        (color_out),
		.depth_confidence (depth_confidence)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (in_valid && !in_stall)
			board.note_pixel('{class_prob, class_index, unc_red, unc_green, unc_blue,
				point_finite, pos_x_mm, pos_y_mm, depth_mm, point_color});
		if (out_valid && !out_stall)
			board.check_point('{keep, class_out, x_out, y_out, z_out, color_out,
				depth_confidence});
		if (cycles > LIMIT_CYCLES) begin
			$display("semantic_point_confidence_filter_top: mismatch");
			$finish;
		end
	end

	// output side: long hold-off on request, otherwise a changing stall pattern
	initial begin : receiver
		stall_mode_t mode;
		int          mode_left;
		int          held;
		mode = FLOW;
		mode_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				for (held = 1; held < HOLD_CYCLES; held++) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = stall_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(40, 160);
				end
				mode_left--;
				case (mode)
					FLOW:    out_stall <= 1'b0;
					LIGHT:   out_stall <= ($urandom_range(0, 9) < 3);
					HEAVY:   out_stall <= ($urandom_range(0, 9) < 7);
					default: out_stall <= mode_left[2];
				endcase
			end
		end
	end

	task automatic drive_pixel(pixel_t px);
		in_valid     <= 1'b1;
		class_prob   <= px.prob;
		class_index  <= px.cls;
		unc_red      <= px.red;
		unc_green    <= px.green;
		unc_blue     <= px.blue;
		point_finite <= px.finite;
		pos_x_mm     <= px.x;
		pos_y_mm     <= px.y;
		depth_mm     <= px.z;
		point_color  <= px.color;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic pixel_t mk(int unsigned prob, int unsigned cls, int unsigned r,
		int unsigned g, int unsigned b, bit fin, int x, int y, int unsigned z,
		int unsigned color);
		pixel_t px;
		px.prob   = 17'(prob);
		px.cls    = 4'(cls);
		px.red    = 8'(r);
		px.green  = 8'(g);
		px.blue   = 8'(b);
		px.finite = fin;
		px.x      = 16'(x);
		px.y      = 16'(y);
		px.z      = 16'(z);
		px.color  = 24'(color);
		return px;
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t      px;
		int unsigned lo, hi, pick, t;
		lo = (board.near_mm < board.far_mm) ? board.near_mm : board.far_mm;
		hi = (board.near_mm < board.far_mm) ? board.far_mm : board.near_mm;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			px.prob = 17'd65536;
		end else if (pick < 25) begin
			px.prob = 17'($urandom_range(65537, 131071));
		end else if (pick < 50) begin
			t = board.prob_thr + $urandom_range(0, 6);
			t = (t < 3) ? 0 : t - 3;
			px.prob = 17'((t > 131071) ? 131071 : t);
		end else begin
			px.prob = 17'($urandom_range(0, 65536));
		end
		px.cls = 4'($urandom_range(0, 15));
		px.finite = ($urandom_range(0, 7) != 0);
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			px.red = 8'd0;
			px.green = 8'd0;
			px.blue = 8'd0;
		end else if (pick < 60) begin
			px.red = 8'($urandom_range(0, 40));
			px.green = 8'($urandom_range(0, 40));
			px.blue = 8'($urandom_range(0, 40));
		end else begin
			px.red = 8'($urandom);
			px.green = 8'($urandom);
			px.blue = 8'($urandom);
		end
		px.x = 16'($urandom);
		px.y = 16'($urandom);
		px.color = 24'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 60)
			px.z = 16'($urandom_range(lo, hi));
		else if (pick < 75)
			px.z = 16'($urandom_range(0, 1) ? board.near_mm : board.far_mm);
		else
			px.z = 16'($urandom_range(0, 65535));
		return px;
	endfunction

	task automatic send_random(int count);
		int left, burst, gap;
		left = count;
		while (left > 0) begin
			gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst = $urandom_range(1, 24);
			if (burst > left) burst = left;
			repeat (burst) drive_pixel(random_pixel());
			left -= burst;
		end
		in_valid <= 1'b0;
	endtask

	task automatic settle();
		while (board.pending() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic configure(int unsigned pthr, int unsigned cthr, int unsigned nr,
		int unsigned fr);
		logic [1:0]  regs[4];
		int unsigned vals[4];
		regs = '{CFG_PROB_THR, CFG_CONF_THR, CFG_NEAR, CFG_FAR};
		vals = '{pthr, cthr, nr, fr};
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= regs[i];
			cfg_wdata <= 17'(vals[i]);
			board.set_reg(regs[i], vals[i]);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	initial begin
		int unsigned p, c, n, f;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// reset thresholds: probability and confidence edges, depth curve ends
		drive_pixel(mk(65536, 15, 0, 0, 0, 1, 32767, -32768, 0, 24'hffffff));
		drive_pixel(mk(0, 0, 0, 0, 0, 1, -32768, 32767, 1000, 24'h000000));
		drive_pixel(mk(32768, 3, 10, 20, 30, 1, 1, -1, 500, 24'h123456));
		drive_pixel(mk(32767, 4, 10, 20, 30, 1, 2, -2, 500, 24'h654321));
		drive_pixel(mk(65536, 5, 255, 255, 255, 1, 3, 3, 1000, 24'hff0000));
		drive_pixel(mk(65536, 6, 127, 127, 127, 1, 4, 4, 6000, 24'h00ff00));
		drive_pixel(mk(65536, 7, 128, 128, 128, 1, 5, 5, 2000, 24'h0000ff));
		drive_pixel(mk(65536, 8, 0, 0, 0, 0, 6, 6, 2000, 24'h808080));
		drive_pixel(mk(65536, 9, 0, 0, 0, 1, 7, 7, 6001, 24'h7f7f7f));
		drive_pixel(mk(65536, 10, 0, 0, 0, 1, 8, 8, 65535, 24'h010203));
		drive_pixel(mk(65536, 11, 0, 0, 0, 1, 9, 9, 499, 24'haaaaaa));
		drive_pixel(mk(65536, 12, 0, 0, 0, 1, 10, 10, 3250, 24'h555555));
		drive_pixel(mk(131071, 13, 0, 0, 0, 1, 11, 11, 501, 24'hc0ffee));
		drive_pixel(mk(65536, 14, 255, 0, 0, 1, 12, 12, 5999, 24'hff00ff));
		drive_pixel(mk(65536, 1, 0, 255, 0, 1, 13, 13, 4000, 24'h00ffff));
		drive_pixel(mk(65536, 2, 0, 0, 255, 1, 14, 14, 800, 24'hffff00));
		in_valid <= 1'b0;
		settle();

		// near equal to far
		configure(32768, 128, 1000, 1000);
		drive_pixel(mk(65536, 1, 0, 0, 0, 1, 0, 0, 999, 24'h111111));
		drive_pixel(mk(65536, 2, 0, 0, 0, 1, 0, 0, 1000, 24'h222222));
		drive_pixel(mk(65536, 3, 0, 0, 0, 1, 0, 0, 1001, 24'h333333));
		in_valid <= 1'b0;
		settle();

		// far below near
		configure(32768, 128, 3000, 1000);
		drive_pixel(mk(65536, 4, 0, 0, 0, 1, 0, 0, 500, 24'h444444));
		drive_pixel(mk(65536, 5, 0, 0, 0, 1, 0, 0, 2000, 24'h555555));
		drive_pixel(mk(65536, 6, 0, 0, 0, 1, 0, 0, 3000, 24'h666666));
		drive_pixel(mk(65536, 7, 0, 0, 0, 1, 0, 0, 65535, 24'h777777));
		in_valid <= 1'b0;
		settle();

		for (int phase = 0; phase < 10; phase++) begin
			case (phase)
				0: begin p = 0;     c = 0;   n = 0;     f = 0;     end
				1: begin p = 65536; c = 255; n = 65535; f = 65535; end
				2: begin p = 32768; c = 128; n = 500;   f = 6000;  end
				3: begin p = 0;     c = 0;   n = 0;     f = 65535; end
				4: begin p = 20000; c = 200; n = 1000;  f = 1000;  end
				5: begin p = 45000; c = 60;  n = 4000;  f = 1500;  end
				6: begin p = 10000; c = 100; n = 0;     f = 1;     end
				7: begin p = 50000; c = 180; n = 65534; f = 65535; end
				default: begin
					p = $urandom_range(0, 65536);
					c = $urandom_range(0, 255);
					n = $urandom_range(0, 20000);
					f = n + $urandom_range(0, 40000);
				end
			endcase
			configure(p, c, n, f);
			if (phase == 2 || phase == 8) hold_req = 1'b1;
			send_random(PHASE_ITEMS);
			settle();
		end

		if (board.errors == 0)
			$display("semantic_point_confidence_filter_top: match");
		else
			$display("semantic_point_confidence_filter_top: mismatch");
		$finish;
	end
endmodule

// ----- files.f -----
sv/spcf_pkg.sv
sv/spcf_front.sv
sv/spcf_div_stage.sv
sv/spcf_sqrt_stage.sv
sv/semantic_point_confidence_filter_top.sv
tb/semantic_point_confidence_filter_top_test.sv
